// ===== rtl/core/osa_pkg.sv =====
// Shared types, constants and the bypass lookup for the obstacle sector accumulator.
// No dependencies; used by obstacle_sector_accumulator and its checker.
`default_nettype none
package osa_pkg;

	localparam int RANGE_W   = 16;
	localparam int THRESH_W  = 12;
	localparam int WINDOW_W  = 10;
	localparam int HLIMIT_W  = 15;
	localparam int INDEX_W   = 10;
	localparam int HEADING_W = 16;
	localparam int COUNT_W   = 13;
	localparam int SECTORS   = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int S_DATA_W  = 48;
	localparam int M_DATA_W  = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OBSTACLE_DIST = 2'd0,
		REG_ACT_THRESH    = 2'd1,
		REG_WINDOW        = 2'd2,
		REG_HEAD_LIMIT    = 2'd3
	} cfg_reg_t;

	localparam logic [RANGE_W-1:0]  OBSTACLE_DIST_RST = 16'd10000;
	localparam logic [THRESH_W-1:0] ACT_THRESH_RST    = 12'd1500;
	localparam logic [WINDOW_W-1:0] WINDOW_RST        = 10'd150;
	localparam logic [HLIMIT_W-1:0] HEAD_LIMIT_RST    = 15'd300;

	typedef logic [COUNT_W-1:0] count_t;

	typedef struct packed {
		logic        evaluated;
		logic        bypass_req;
		logic signed [2:0] bypass_direction;
		logic [2:0]  sector_flags;
	} result_t;

	// Eight-way bypass table indexed by the sector flags (bit 0 = sector 0).
	function automatic logic signed [2:0] bypass_lookup(input logic [2:0] flags);
		logic signed [2:0] dir;
		case (flags)
			3'd0:    dir = 3'sd0;
			3'd1:    dir = 3'sd1;
			3'd2:    dir = 3'sd1;
			3'd3:    dir = 3'sd2;
			3'd4:    dir = -3'sd1;
			3'd5:    dir = 3'sd0;
			3'd6:    dir = -3'sd2;
			3'd7:    dir = 3'sd3;
			default: dir = 3'sd0;
		endcase
		return dir;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/obstacle_sector_accumulator.sv =====
// Obstacle sector accumulator: three evidence counters fed by range samples,
// evaluated into sector flags and a bypass direction. Uses osa_pkg.
// A request passes through the input register, then the result register.
// Throughput: one request per cycle unless the result side stalls; the counter read-modify-write sits between them.
// Back pressure on the result side stalls the input register only when both are full.
// arst_n clears counters, valid flags and configuration to their defaults at once.
`default_nettype none
module obstacle_sector_accumulator (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// s_tdata: range_mm[15:0], sample_index[25:16], heading_error_mrad[41:26], zero pad
	input  wire logic [osa_pkg::S_DATA_W-1:0]     s_tdata,
	// s_tuser: mode
	input  wire logic                             s_tuser,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// m_tdata: sector_flags[2:0], bypass_direction[5:3], bypass_req[6], evaluated[7]
	output logic [osa_pkg::M_DATA_W-1:0]          m_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [osa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [osa_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [osa_pkg::RANGE_W-1:0]  obstacle_dist_q;
	logic [osa_pkg::THRESH_W-1:0] act_thresh_q;
	logic [osa_pkg::WINDOW_W-1:0] window_q;
	logic [osa_pkg::HLIMIT_W-1:0] head_limit_q;

	osa_pkg::count_t counter_q [osa_pkg::SECTORS];

	logic                            valid_s1;
	logic                            mode_s1;
	logic [osa_pkg::RANGE_W-1:0]     range_s1;
	logic [osa_pkg::INDEX_W-1:0]     index_s1;
	logic [osa_pkg::HEADING_W-1:0]   heading_s1;

	logic                            out_valid_q;
	osa_pkg::result_t                result_q;

	logic                            advance;
	logic [osa_pkg::INDEX_W+1:0]     scaled_idx;
	logic [1:0]                      sector;
	osa_pkg::count_t                 cur_count;
	logic [osa_pkg::COUNT_W:0]       bumped;
	logic [osa_pkg::COUNT_W:0]       decayed;
	logic                            hit;
	logic [osa_pkg::HEADING_W-1:0]   head_mag;
	logic                            suppressed;
	logic [2:0]                      flags;
	logic signed [2:0]               dir;
	osa_pkg::result_t                result_d;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = result_q;

	always_comb begin
		scaled_idx = {2'b00, index_s1} + {1'b0, index_s1, 1'b0};
		if (scaled_idx < {2'b00, window_q}) begin
			sector = 2'd0;
		end else if (scaled_idx < {1'b0, window_q, 1'b0}) begin
			sector = 2'd1;
		end else begin
			sector = 2'd2;
		end
		case (sector)
			2'd0:    cur_count = counter_q[0];
			2'd1:    cur_count = counter_q[1];
			default: cur_count = counter_q[2];
		endcase
		hit = (range_s1 <= obstacle_dist_q) && (cur_count < {act_thresh_q, 1'b0});
		bumped = hit ? ({1'b0, cur_count} + 14'd3) : {1'b0, cur_count};
		decayed = (bumped != '0) ? (bumped - 14'd1) : bumped;

		// magnitude fits 16 bits unsigned, -32768 gives 32768
		head_mag = heading_s1[osa_pkg::HEADING_W-1] ? (~heading_s1 + 16'd1) : heading_s1;
		suppressed = head_mag > {1'b0, head_limit_q};
		for (int k = 0; k < osa_pkg::SECTORS; k++) begin
			flags[k] = counter_q[k] > {1'b0, act_thresh_q};
		end
		dir = osa_pkg::bypass_lookup(flags);

		result_d = '0;
		if (mode_s1 && !suppressed) begin
			result_d.sector_flags     = flags;
			result_d.bypass_direction = dir;
			result_d.bypass_req       = (dir != 3'sd0);
			result_d.evaluated        = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obstacle_dist_q <= osa_pkg::OBSTACLE_DIST_RST;
			act_thresh_q    <= osa_pkg::ACT_THRESH_RST;
			window_q        <= osa_pkg::WINDOW_RST;
			head_limit_q    <= osa_pkg::HEAD_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (osa_pkg::cfg_reg_t'(cfg_index))
				osa_pkg::REG_OBSTACLE_DIST: obstacle_dist_q <= cfg_data;
				osa_pkg::REG_ACT_THRESH:    act_thresh_q <= cfg_data[osa_pkg::THRESH_W-1:0];
				osa_pkg::REG_WINDOW:        window_q <= cfg_data[osa_pkg::WINDOW_W-1:0];
				osa_pkg::REG_HEAD_LIMIT:    head_limit_q <= cfg_data[osa_pkg::HLIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < osa_pkg::SECTORS; k++) begin
				counter_q[k] <= '0;
			end
		end else if (advance && !mode_s1) begin
			counter_q[sector] <= decayed[osa_pkg::COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1    <= s_tuser;
			range_s1   <= s_tdata[15:0];
			index_s1   <= s_tdata[25:16];
			heading_s1 <= s_tdata[41:26];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/osa_checker.sv =====
// Port-level checks for obstacle_sector_accumulator, bound to the top level.
// Depends on osa_pkg for widths.
`default_nettype none
module osa_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic [osa_pkg::M_DATA_W-1:0]  m_tdata,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// non-evaluated result carries no flags or direction
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[7] |-> m_tdata[6:0] == 7'd0)
		else $error("non-evaluated result not zero");

	// bypass request matches a nonzero direction
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[6] == (m_tdata[5:3] != 3'd0))
		else $error("bypass_req inconsistent with direction");

	// no flags or the two outer sectors: go straight
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] == 3'd0 || m_tdata[2:0] == 3'd5) |-> m_tdata[5:3] == 3'd0)
		else $error("straight pattern gave a bypass");

endmodule

bind obstacle_sector_accumulator osa_checker u_osa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tdata  (m_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);
`default_nettype wire
